FILE: sv/cue_trk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cue_trk_pkg
// Shared types and constants of the cue-sheet track bounds tracker.
// ----------------------------------------------------------------------------
package cue_trk_pkg;

  localparam int unsigned FRAME_BITS = 20;
  localparam int unsigned KIND_BITS  = 3;
  localparam int unsigned GAP_BITS   = 2;
  localparam int unsigned DUR_BITS   = 24;

  // frames * 1000 / 75 == frames * 40 / 3; the *40 is two shifted adds
  localparam int unsigned X_BITS      = FRAME_BITS + 6;
  localparam int unsigned RECIP_BITS  = 32;
  localparam int unsigned PROD_BITS   = X_BITS + RECIP_BITS;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned Q_BITS      = PROD_BITS - RECIP_SHIFT;
  // ceil(2^33 / 3), exact quotient by 3 for any dividend below 2^32
  localparam logic [RECIP_BITS-1:0] RECIP_3 = 32'hAAAA_AAAB;
  localparam logic [DUR_BITS-1:0]   DUR_MAX = {DUR_BITS{1'b1}};

  typedef enum logic [KIND_BITS-1:0] {
    EV_FILE    = 3'd0,
    EV_TRACK   = 3'd1,
    EV_INDEX00 = 3'd2,
    EV_INDEX   = 3'd3,
    EV_END     = 3'd4
  } evt_kind_e;

  typedef enum logic [GAP_BITS-1:0] {
    GAP_PREV       = 2'd0,
    GAP_PREV_FIRST = 2'd1,
    GAP_CURRENT    = 2'd2,
    GAP_SKIP       = 2'd3
  } gap_mode_e;

  // track bounds captured when an event closes a track
  typedef struct packed {
    logic [FRAME_BITS-1:0] start_frame;
    logic                  start_known;
    logic [FRAME_BITS-1:0] end_frame;
    logic                  is_final;
  } snap_t;

endpackage

FILE: sv/cue_trk_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cue_trk_evt_if
// Event channel: cue-sheet event kind and frame position.
// ----------------------------------------------------------------------------
interface cue_trk_evt_if;
  import cue_trk_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  event_kind;
  logic [FRAME_BITS-1:0] frame_position;

  modport source (output valid, output event_kind, output frame_position, input ready);
  modport sink   (input valid, input event_kind, input frame_position, output ready);
endinterface

FILE: sv/cue_trk_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cue_trk_res_if
// Result channel: bounds and duration of one track.
// ----------------------------------------------------------------------------
interface cue_trk_res_if;
  import cue_trk_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] start_frame;
  logic                  start_known;
  logic [FRAME_BITS-1:0] end_frame;
  logic [DUR_BITS-1:0]   duration_ms;
  logic                  is_final;
  logic                  bad_order;

  modport source (output valid, output start_frame, output start_known, output end_frame,
                  output duration_ms, output is_final, output bad_order, input ready);
  modport sink   (input valid, input start_frame, input start_known, input end_frame,
                  input duration_ms, input is_final, input bad_order, output ready);
endinterface

FILE: sv/cue_trk_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cue_trk_cfg_if
// Configuration write channel for the gap mode register.
// ----------------------------------------------------------------------------
interface cue_trk_cfg_if;
  import cue_trk_pkg::*;

  logic                valid;
  logic                ready;
  logic [GAP_BITS-1:0] gap_mode;

  modport source (output valid, output gap_mode, input ready);
  modport sink   (input valid, input gap_mode, output ready);
endinterface

FILE: sv/cue_trk_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cue_trk_state
// Track bookkeeping: updates the start marks on each event and captures the
// bounds of a closed track into the snapshot register.
// ----------------------------------------------------------------------------
module cue_trk_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  cue_trk_evt_if.sink         evt_i,
  cue_trk_cfg_if.sink         cfg_i,
  output logic                snap_vld_o,
  output cue_trk_pkg::snap_t  snap_o,
  input  logic                snap_rdy_i
);
  import cue_trk_pkg::*;

  gap_mode_e             gap_mode_q;
  logic [FRAME_BITS-1:0] pend_q, pend_d;
  logic                  pend_set_q, pend_set_d;
  logic [FRAME_BITS-1:0] ts_q, ts_d;
  logic                  ts_set_q, ts_set_d;
  logic [FRAME_BITS-1:0] te_q, te_d;
  logic                  te_set_q, te_set_d;
  logic                  await_q, await_d;
  logic                  seen_q, seen_d;
  logic                  snap_vld_q, snap_vld_d;
  snap_t                 snap_q, snap_d;
  logic                  evt_acc;
  logic                  emit;
  logic                  fin;
  evt_kind_e             kind;
  logic [FRAME_BITS-1:0] pos;

  assign evt_i.ready = !snap_vld_q || snap_rdy_i;
  assign evt_acc     = evt_i.valid && evt_i.ready;
  assign cfg_i.ready = 1'b1;
  assign kind        = evt_kind_e'(evt_i.event_kind);
  assign pos         = evt_i.frame_position;

  always_comb begin
    pend_d     = pend_q;
    pend_set_d = pend_set_q;
    ts_d       = ts_q;
    ts_set_d   = ts_set_q;
    te_d       = te_q;
    te_set_d   = te_set_q;
    await_d    = await_q;
    seen_d     = seen_q;
    emit       = 1'b0;
    fin        = 1'b0;
    if (evt_acc) begin
      unique case (kind)
        EV_FILE: begin
          pend_d     = '0;
          pend_set_d = 1'b0;
          await_d    = 1'b1;
        end
        EV_TRACK: begin
          ts_d     = '0;
          ts_set_d = 1'b0;
          te_d     = '0;
          te_set_d = 1'b0;
          seen_d   = 1'b0;
        end
        EV_INDEX00: begin
          if (await_q) begin
            if (gap_mode_q == GAP_PREV_FIRST || gap_mode_q == GAP_CURRENT) begin
              pend_d     = pos;
              pend_set_d = 1'b1;
            end
          end else if (gap_mode_q == GAP_SKIP) begin
            te_d     = pos;
            te_set_d = 1'b1;
          end else if (gap_mode_q == GAP_CURRENT) begin
            te_d       = pos;
            te_set_d   = 1'b1;
            ts_d       = pend_q;
            ts_set_d   = pend_set_q;
            pend_d     = pos;
            pend_set_d = 1'b1;
          end
        end
        EV_INDEX: begin
          if (await_q) begin
            await_d = 1'b0;
            if (!pend_set_q) begin
              pend_d     = pos;
              pend_set_d = 1'b1;
            end
          end else if (!seen_q) begin
            if (!ts_set_q) begin
              ts_d       = pend_q;
              ts_set_d   = pend_set_q;
              pend_d     = pos;
              pend_set_d = 1'b1;
            end
            if (!te_set_q) begin
              te_d     = pos;
              te_set_d = 1'b1;
            end
            seen_d = 1'b1;
            emit   = 1'b1;
          end
        end
        EV_END: begin
          ts_d     = pend_q;
          ts_set_d = pend_set_q;
          te_d     = '0;
          te_set_d = 1'b1;
          emit     = 1'b1;
          fin      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    snap_vld_d = snap_vld_q;
    snap_d     = snap_q;
    if (evt_i.ready) begin
      snap_vld_d         = emit;
      snap_d.start_frame = ts_set_d ? ts_d : '0;
      snap_d.start_known = ts_set_d;
      snap_d.end_frame   = te_d;
      snap_d.is_final    = fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_mode_q <= GAP_PREV;
      pend_q     <= '0;
      pend_set_q <= 1'b1;
      ts_q       <= '0;
      ts_set_q   <= 1'b1;
      te_q       <= '0;
      te_set_q   <= 1'b1;
      await_q    <= 1'b0;
      seen_q     <= 1'b0;
      snap_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        gap_mode_q <= gap_mode_e'(cfg_i.gap_mode);
      end
      pend_q     <= pend_d;
      pend_set_q <= pend_set_d;
      ts_q       <= ts_d;
      ts_set_q   <= ts_set_d;
      te_q       <= te_d;
      te_set_q   <= te_set_d;
      await_q    <= await_d;
      seen_q     <= seen_d;
      snap_vld_q <= snap_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_vld_o = snap_vld_q;
  assign snap_o     = snap_q;

  // a new snapshot only follows an event transfer
  a_snap_from_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(snap_vld_q) |-> $past(evt_i.valid && evt_i.ready))
    else $error("snapshot appeared without an event transfer");

  // unknown start always reads as zero
  a_unknown_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_vld_q && !snap_q.start_known) |-> (snap_q.start_frame == '0))
    else $error("unknown start with nonzero frame");

  // the end-of-sheet result is open-ended
  a_final_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_vld_q && snap_q.is_final) |-> (snap_q.end_frame == '0))
    else $error("final track carries an end frame");

endmodule

FILE: sv/cue_trk_dur.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cue_trk_dur
// Ordering check and duration in milliseconds, frames * 40 / 3, with the
// divide by three done as a reciprocal multiply; drives the result register.
// ----------------------------------------------------------------------------
module cue_trk_dur (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                snap_vld_i,
  input  cue_trk_pkg::snap_t  snap_i,
  output logic                snap_rdy_o,
  cue_trk_res_if.source       res_o
);
  import cue_trk_pkg::*;

  // scaled-difference stage
  logic                  x_vld_q;
  snap_t                 x_snap_q;
  logic                  x_bad_q;
  logic [X_BITS-1:0]     x_q;
  logic                  x_rdy;
  logic                  bad;
  logic [FRAME_BITS-1:0] diff;
  logic [X_BITS-1:0]     x_d;

  // result register
  logic                  res_vld_q;
  snap_t                 res_snap_q;
  logic                  res_bad_q;
  logic [DUR_BITS-1:0]   res_dur_q;
  logic                  res_rdy;
  logic [PROD_BITS-1:0]  prod;
  logic [Q_BITS-1:0]     quot;
  logic [DUR_BITS-1:0]   dur;

  assign res_rdy    = !res_vld_q || res_o.ready;
  assign x_rdy      = !x_vld_q || res_rdy;
  assign snap_rdy_o = x_rdy;

  always_comb begin
    bad  = (snap_i.end_frame != '0) &&
           (!snap_i.start_known || (snap_i.start_frame >= snap_i.end_frame));
    diff = snap_i.end_frame - snap_i.start_frame;
    if (bad || snap_i.end_frame == '0) begin
      x_d = '0;
    end else begin
      x_d = {1'b0, diff, 5'b0} + {3'b0, diff, 3'b0};
    end
  end

  always_comb begin
    prod = PROD_BITS'(x_q) * PROD_BITS'(RECIP_3);
    quot = prod[PROD_BITS-1:RECIP_SHIFT];
    if (quot > Q_BITS'(DUR_MAX)) begin
      dur = DUR_MAX;
    end else begin
      dur = quot[DUR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (x_rdy) begin
        x_vld_q <= snap_vld_i;
      end
      if (res_rdy) begin
        res_vld_q <= x_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_rdy) begin
      x_snap_q <= snap_i;
      x_bad_q  <= bad;
      x_q      <= x_d;
    end
    if (res_rdy) begin
      res_snap_q <= x_snap_q;
      res_bad_q  <= x_bad_q;
      res_dur_q  <= dur;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.start_frame = res_snap_q.start_frame;
  assign res_o.start_known = res_snap_q.start_known;
  assign res_o.end_frame   = res_snap_q.end_frame;
  assign res_o.duration_ms = res_dur_q;
  assign res_o.is_final    = res_snap_q.is_final;
  assign res_o.bad_order   = res_bad_q;

  // bad ordering never reports a duration
  a_bad_no_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_bad_q) |-> (res_dur_q == '0))
    else $error("bad order with nonzero duration");

  // a nonzero duration needs a start strictly before the end
  a_dur_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_dur_q != '0) |->
      (res_snap_q.start_known && res_snap_q.start_frame < res_snap_q.end_frame))
    else $error("duration reported for misordered bounds");

endmodule

FILE: sv/cue_track_bounds_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cue_track_bounds_tracker_top
// Cue-sheet track bounds tracker: turns file, track, index and end events into
// per-track start/end frames, duration in milliseconds and an ordering flag.
//
//   channel  dir   handshake      payload
//   evt_i    in    valid/ready    event_kind, frame_position
//   cfg_i    in    valid/ready    gap_mode (ready always high)
//   res_o    out   valid/ready    start_frame, start_known, end_frame,
//                                 duration_ms, is_final, bad_order
//
// One event per cycle while evt_i.ready is high; a result passes through the
// snapshot, scaled-difference and multiply stage registers, in that order.
// Reset leaves the start, start-known and end flags set, the gap mode at zero.
// A stalled output fills the stages behind it; evt_i.ready drops only when all
// three hold a result.
// ----------------------------------------------------------------------------
module cue_track_bounds_tracker_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  cue_trk_evt_if.sink   evt_i,
  cue_trk_cfg_if.sink   cfg_i,
  cue_trk_res_if.source res_o
);
  import cue_trk_pkg::*;

  logic  snap_vld;
  logic  snap_rdy;
  snap_t snap;

  cue_trk_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_i),
    .cfg_i      (cfg_i),
    .snap_vld_o (snap_vld),
    .snap_o     (snap),
    .snap_rdy_i (snap_rdy)
  );

  cue_trk_dur u_dur (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .snap_vld_i (snap_vld),
    .snap_i     (snap),
    .snap_rdy_o (snap_rdy),
    .res_o      (res_o)
  );

endmodule
